### design/pmrb_pkg.sv
// Shared types and constants for the pin multiplexing register bank.
package pmrb_pkg;

  // Pins per port and field widths
  localparam int PINS_PER_PORT = 32;
  localparam int PIN_W         = 5;
  localparam int PORT_SEL_W    = 2;

  // Request codes; the unused code behaves as a read
  localparam logic [1:0] REQ_SET_MUX    = 2'd0;
  localparam logic [1:0] REQ_SET_PULLUP = 2'd1;
  localparam logic [1:0] REQ_READ       = 2'd2;

  // Mux code bit positions
  localparam int MUX_ALT_BIT     = 0;
  localparam int MUX_GPIO_BIT    = 1;
  localparam int MUX_DIR_BIT     = 2;
  localparam int MUX_OCONF_LSB   = 4;
  localparam int MUX_ICONFA_LSB  = 8;
  localparam int MUX_ICONFB_LSB  = 10;

  // One request as held in the input register
  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  pin_id;
    logic [11:0] mux_code;
    logic        pull_up;
  } req_t;

  // Fields of one pin as returned in a result
  typedef struct packed {
    logic       gpio_used;
    logic       alt_function;
    logic       direction;
    logic [1:0] out_conf;
    logic [1:0] in_conf_a;
    logic [1:0] in_conf_b;
    logic       pull_up_enabled;
  } pin_state_t;

  // Pipeline control between the stages
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

endpackage

### design/pmrb_in_reg.sv
// Input register stage: captures one request transfer and holds it until it moves on.
module pmrb_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pmrb_pkg::req_t       req_in,
  input  logic                 advance,
  output pmrb_pkg::req_t       req,
  output logic                 valid
);

  // Accept when empty or when the held request moves on this cycle
  assign in_ready = !valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= req_in;
    end
  end

endmodule

### design/pmrb_bank.sv
// Per-port field registers with the combinational read and registered write-back of one pin.
module pmrb_bank #(
  parameter int NUM_PORTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pmrb_pkg::req_t        req,
  input  pmrb_pkg::stage_ctrl_t ctrl,
  output pmrb_pkg::pin_state_t  state
);

  localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [pmrb_pkg::PINS_PER_PORT-1:0]   gpio_use_bits    [NUM_PORTS];
  logic [pmrb_pkg::PINS_PER_PORT-1:0]   direction_bits   [NUM_PORTS];
  logic [pmrb_pkg::PINS_PER_PORT-1:0]   alt_func_bits    [NUM_PORTS];
  logic [pmrb_pkg::PINS_PER_PORT-1:0]   pullup_bits      [NUM_PORTS];
  logic [2*pmrb_pkg::PINS_PER_PORT-1:0] out_conf_fields  [NUM_PORTS];
  logic [2*pmrb_pkg::PINS_PER_PORT-1:0] in_conf_a_fields [NUM_PORTS];
  logic [2*pmrb_pkg::PINS_PER_PORT-1:0] in_conf_b_fields [NUM_PORTS];

  logic [pmrb_pkg::PORT_SEL_W-1:0] port;
  logic [pmrb_pkg::PIN_W-1:0]      pin;
  logic [PORT_W-1:0]               idx;
  logic                            port_ok;
  logic                            set_mux;
  logic                            set_pullup;
  logic                            mux_gpio;
  logic                            wr_en;
  pmrb_pkg::pin_state_t            cur;
  pmrb_pkg::pin_state_t            upd;

  // Address decode
  assign port    = req.pin_id[6:5];
  assign pin     = req.pin_id[4:0];
  assign idx     = PORT_W'(port);
  assign port_ok = ({30'd0, port} < 32'(NUM_PORTS));
  assign wr_en   = ctrl.valid && ctrl.advance && port_ok;

  always_comb begin
    set_mux    = 1'b0;
    set_pullup = 1'b0;
    unique case (req.req_type)
      pmrb_pkg::REQ_SET_MUX:    set_mux    = 1'b1;
      pmrb_pkg::REQ_SET_PULLUP: set_pullup = 1'b1;
      default:                  ;
    endcase
  end

  assign mux_gpio = req.mux_code[pmrb_pkg::MUX_GPIO_BIT];

  // Current fields of the addressed pin
  always_comb begin
    cur.gpio_used       = gpio_use_bits[idx][pin];
    cur.alt_function    = alt_func_bits[idx][pin];
    cur.direction       = direction_bits[idx][pin];
    cur.out_conf        = out_conf_fields[idx][2*pin +: 2];
    cur.in_conf_a       = in_conf_a_fields[idx][2*pin +: 2];
    cur.in_conf_b       = in_conf_b_fields[idx][2*pin +: 2];
    cur.pull_up_enabled = pullup_bits[idx][pin];
  end

  // Fields after the request
  always_comb begin
    upd = cur;
    if (set_mux) begin
      upd.gpio_used = mux_gpio;
      upd.direction = req.mux_code[pmrb_pkg::MUX_DIR_BIT];
      if (mux_gpio) begin
        upd.out_conf  = req.mux_code[pmrb_pkg::MUX_OCONF_LSB +: 2];
        upd.in_conf_a = req.mux_code[pmrb_pkg::MUX_ICONFA_LSB +: 2];
        upd.in_conf_b = req.mux_code[pmrb_pkg::MUX_ICONFB_LSB +: 2];
      end else begin
        upd.alt_function = req.mux_code[pmrb_pkg::MUX_ALT_BIT];
      end
    end
    if (set_pullup) begin
      upd.pull_up_enabled = req.pull_up;
    end
  end

  // Unpopulated ports read as zero
  assign state = port_ok ? upd : '0;

  // Write back the addressed pin as the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        gpio_use_bits[i]    <= '0;
        direction_bits[i]   <= '0;
        alt_func_bits[i]    <= '0;
        pullup_bits[i]      <= '0;
        out_conf_fields[i]  <= '0;
        in_conf_a_fields[i] <= '0;
        in_conf_b_fields[i] <= '0;
      end
    end else if (wr_en) begin
      gpio_use_bits[idx][pin]         <= upd.gpio_used;
      direction_bits[idx][pin]        <= upd.direction;
      alt_func_bits[idx][pin]         <= upd.alt_function;
      pullup_bits[idx][pin]           <= upd.pull_up_enabled;
      out_conf_fields[idx][2*pin +: 2]  <= upd.out_conf;
      in_conf_a_fields[idx][2*pin +: 2] <= upd.in_conf_a;
      in_conf_b_fields[idx][2*pin +: 2] <= upd.in_conf_b;
    end
  end

endmodule

### design/pmrb_out_reg.sv
// Result register: holds one result transfer until the consumer takes it.
module pmrb_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  pmrb_pkg::pin_state_t state_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pmrb_pkg::pin_state_t state,
  output logic                 can_load
);

  // Free when empty or when the held result leaves this cycle
  assign can_load = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      state <= state_in;
    end
  end

endmodule

### design/pin_mux_register_bank_unit.sv
// Top level of the pin multiplexing register bank.
// Holds mux and pull-up fields for NUM_PORTS ports of 32 pins. A request enters an
// input register, its pin is read, updated and written back to the bank while the
// result loads into the output register; one request is taken every cycle unless the
// consumer stalls the output register, and its result is offered once it loads there,
// the pin read-modify-write in the bank being the only logic between the two registers.
// Requests to a port beyond NUM_PORTS change nothing and return all zero.
module pin_mux_register_bank_unit #(
  parameter int NUM_PORTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [6:0]  pin_id,
  input  logic [11:0] mux_code,
  input  logic        pull_up,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        gpio_used,
  output logic        alt_function,
  output logic        direction,
  output logic [1:0]  out_conf,
  output logic [1:0]  in_conf_a,
  output logic [1:0]  in_conf_b,
  output logic        pull_up_enabled
);

  pmrb_pkg::req_t        req_in;
  pmrb_pkg::req_t        req;
  pmrb_pkg::stage_ctrl_t ctrl;
  pmrb_pkg::pin_state_t  next_state;
  pmrb_pkg::pin_state_t  res;
  logic                  s1_valid;
  logic                  can_load;

  assign req_in.req_type = req_type;
  assign req_in.pin_id   = pin_id;
  assign req_in.mux_code = mux_code;
  assign req_in.pull_up  = pull_up;

  assign ctrl.valid   = s1_valid;
  assign ctrl.advance = s1_valid && can_load;

  pmrb_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_in   (req_in),
    .advance  (ctrl.advance),
    .req      (req),
    .valid    (s1_valid)
  );

  pmrb_bank #(
    .NUM_PORTS (NUM_PORTS)
  ) u_bank (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .ctrl  (ctrl),
    .state (next_state)
  );

  pmrb_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_valid),
    .state_in  (next_state),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .state     (res),
    .can_load  (can_load)
  );

  assign gpio_used       = res.gpio_used;
  assign alt_function    = res.alt_function;
  assign direction       = res.direction;
  assign out_conf        = res.out_conf;
  assign in_conf_a       = res.in_conf_a;
  assign in_conf_b       = res.in_conf_b;
  assign pull_up_enabled = res.pull_up_enabled;

endmodule

### sim/tb_pin_mux_register_bank_unit.sv
// Self-checking testbench for the pin multiplexing register bank top level.
`timescale 1ns / 100ps

module tb_pin_mux_register_bank_unit;

  localparam int NUM_PORTS = 4;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 616;
  localparam int REPORT_MAX = 10;
  // Unused request code, behaves as a read
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Tracks the pin bank contents and the queue of pin states still to come back
  class pin_bank_scoreboard #(int PORTS = 4);
    logic [31:0] gpio_mask [PORTS];
    logic [31:0] dir_mask  [PORTS];
    logic [31:0] alt_mask  [PORTS];
    logic [31:0] pu_mask   [PORTS];
    logic [63:0] oconf_word [PORTS];
    logic [63:0] iconfa_word [PORTS];
    logic [63:0] iconfb_word [PORTS];
    pmrb_pkg::pin_state_t pending_states [$];
    int          mismatches;
    int          checked;

    function new();
      for (int p = 0; p < PORTS; p++) begin
        gpio_mask[p]   = '0;
        dir_mask[p]    = '0;
        alt_mask[p]    = '0;
        pu_mask[p]     = '0;
        oconf_word[p]  = '0;
        iconfa_word[p] = '0;
        iconfb_word[p] = '0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    // Apply one accepted request to the bank copy and queue the pin state after it
    function void note_request(pmrb_pkg::req_t r);
      int unsigned          port;
      int unsigned          pin;
      pmrb_pkg::pin_state_t st;
      port = 32'(r.pin_id[6:5]);
      pin  = 32'(r.pin_id[4:0]);
      st   = '0;
      if (port < PORTS) begin
        if (r.req_type == pmrb_pkg::REQ_SET_MUX) begin
          gpio_mask[port][pin] = r.mux_code[pmrb_pkg::MUX_GPIO_BIT];
          dir_mask[port][pin]  = r.mux_code[pmrb_pkg::MUX_DIR_BIT];
          if (r.mux_code[pmrb_pkg::MUX_GPIO_BIT]) begin
            oconf_word[port][2*pin +: 2]  = r.mux_code[pmrb_pkg::MUX_OCONF_LSB +: 2];
            iconfa_word[port][2*pin +: 2] = r.mux_code[pmrb_pkg::MUX_ICONFA_LSB +: 2];
            iconfb_word[port][2*pin +: 2] = r.mux_code[pmrb_pkg::MUX_ICONFB_LSB +: 2];
          end else begin
            alt_mask[port][pin] = r.mux_code[pmrb_pkg::MUX_ALT_BIT];
          end
        end else if (r.req_type == pmrb_pkg::REQ_SET_PULLUP) begin
          pu_mask[port][pin] = r.pull_up;
        end
        st.gpio_used       = gpio_mask[port][pin];
        st.alt_function    = alt_mask[port][pin];
        st.direction       = dir_mask[port][pin];
        st.out_conf        = oconf_word[port][2*pin +: 2];
        st.in_conf_a       = iconfa_word[port][2*pin +: 2];
        st.in_conf_b       = iconfb_word[port][2*pin +: 2];
        st.pull_up_enabled = pu_mask[port][pin];
      end
      pending_states.push_back(st);
    endfunction

    // Compare one returned pin state with the oldest one waiting
    function void check_result(pmrb_pkg::pin_state_t got);
      pmrb_pkg::pin_state_t want;
      if (pending_states.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: nothing waiting, got %b", got);
        return;
      end
      want = pending_states.pop_front();
      checked++;
      if (got.gpio_used !== want.gpio_used || got.alt_function !== want.alt_function ||
          got.direction !== want.direction || got.out_conf !== want.out_conf ||
          got.in_conf_a !== want.in_conf_a || got.in_conf_b !== want.in_conf_b ||
          got.pull_up_enabled !== want.pull_up_enabled) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch on result %0d: exp gpio=%b alt=%b dir=%b oc=%b ia=%b ib=%b pu=%b",
                   checked, want.gpio_used, want.alt_function, want.direction,
                   want.out_conf, want.in_conf_a, want.in_conf_b, want.pull_up_enabled);
          $display("                         got gpio=%b alt=%b dir=%b oc=%b ia=%b ib=%b pu=%b",
                   got.gpio_used, got.alt_function, got.direction,
                   got.out_conf, got.in_conf_a, got.in_conf_b, got.pull_up_enabled);
        end
      end
    endfunction

    function int outstanding();
      return pending_states.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [6:0]  pin_id = '0;
  logic [11:0] mux_code = '0;
  logic        pull_up = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        gpio_used;
  logic        alt_function;
  logic        direction;
  logic [1:0]  out_conf;
  logic [1:0]  in_conf_a;
  logic [1:0]  in_conf_b;
  logic        pull_up_enabled;

  pin_bank_scoreboard #(NUM_PORTS) sb;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int kind_count [4] = '{0, 0, 0, 0};

  pin_mux_register_bank_unit #(.NUM_PORTS(NUM_PORTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .pin_id(pin_id), .mux_code(mux_code), .pull_up(pull_up),
    .out_valid(out_valid), .out_ready(out_ready),
    .gpio_used(gpio_used), .alt_function(alt_function), .direction(direction),
    .out_conf(out_conf), .in_conf_a(in_conf_a), .in_conf_b(in_conf_b),
    .pull_up_enabled(pull_up_enabled)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off counted here on request
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({gpio_used, alt_function, direction, out_conf,
                       in_conf_a, in_conf_b, pull_up_enabled});
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.outstanding());
    $display("FAIL");
    $finish;
  end

  // Offer one request and wait for its transfer; valid stays high afterwards
  task automatic offer_request(input logic [1:0] kind, input logic [6:0] pin,
                               input logic [11:0] code, input logic pu);
    int gap;
    gap = 0;
    // Each cycle idles with the given chance
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    req_type = kind;
    pin_id   = pin;
    mux_code = code;
    pull_up  = pu;
    do @(posedge clk); while (!in_ready);
    sb.note_request({kind, pin, code, pu});
    kind_count[kind]++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Sender pause until every queued pin state has come back
  task automatic drain_results();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Half the time a pin at a word or port boundary, so writes get read back
  function automatic logic [6:0] pick_pin();
    if ($urandom_range(1))
      return 7'($urandom_range(127));
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd15;
      2: return 7'd16;
      3: return 7'd31;
      4: return 7'd32;
      5: return 7'd95;
      6: return 7'd96;
      default: return 7'd127;
    endcase
  endfunction

  task automatic random_request();
    int pick;
    logic [1:0] kind;
    pick = $urandom_range(99);
    if (pick < 40)      kind = pmrb_pkg::REQ_SET_MUX;
    else if (pick < 65) kind = pmrb_pkg::REQ_SET_PULLUP;
    else if (pick < 95) kind = pmrb_pkg::REQ_READ;
    else                kind = REQ_UNUSED;
    offer_request(kind, pick_pin(), 12'($urandom_range(4095)), 1'($urandom_range(1)));
  endtask

  // Mostly configure-then-read sequences on one pin, the rest loose requests
  task automatic run_phase(input int n_items, input bit with_hold);
    int sent;
    bit paused;
    bit held;
    logic [6:0] pin;
    sent   = 0;
    paused = 1'b0;
    held   = 1'b0;
    while (sent < n_items) begin
      if (with_hold && !held && sent >= 20) begin
        held = 1'b1;
        hold_asked++;
      end
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        release_bus();
        drain_results();
      end
      if ($urandom_range(9) < 4) begin
        pin = pick_pin();
        offer_request(pmrb_pkg::REQ_SET_MUX, pin, 12'($urandom_range(4095)),
                      1'($urandom_range(1)));
        offer_request(pmrb_pkg::REQ_SET_PULLUP, pin, 12'($urandom_range(4095)),
                      1'($urandom_range(1)));
        offer_request(pmrb_pkg::REQ_READ, pin, 12'($urandom_range(4095)),
                      1'($urandom_range(1)));
        sent += 3;
      end else begin
        random_request();
        sent++;
      end
    end
    release_bus();
    drain_results();
  endtask

  // Main sequence
  initial begin
    int total;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset state, boundary pins, both mux code branches, pull-up, unused code
    offer_request(pmrb_pkg::REQ_READ,       7'd0,   12'h000, 1'b0);
    offer_request(pmrb_pkg::REQ_READ,       7'd127, 12'hFFF, 1'b1);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd0,   12'hFFF, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd0,   12'h001, 1'b1);
    offer_request(REQ_UNUSED,               7'd0,   12'hFFF, 1'b1);
    offer_request(pmrb_pkg::REQ_SET_PULLUP, 7'd0,   12'h000, 1'b1);
    offer_request(pmrb_pkg::REQ_SET_PULLUP, 7'd127, 12'hFFF, 1'b1);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd127, 12'hFFF, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd127, 12'h0C8, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd31,  12'hA56, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd32,  12'h5AE, 1'b1);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd15,  12'hC36, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd16,  12'h3F6, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_PULLUP, 7'd0,   12'hFFF, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd0,   12'h002, 1'b0);
    offer_request(pmrb_pkg::REQ_SET_MUX,    7'd64,  12'h0CB, 1'b1);
    offer_request(pmrb_pkg::REQ_READ,       7'd0,   12'h000, 1'b0);
    offer_request(pmrb_pkg::REQ_READ,       7'd15,  12'h000, 1'b0);
    offer_request(pmrb_pkg::REQ_READ,       7'd16,  12'h000, 1'b0);
    offer_request(pmrb_pkg::REQ_READ,       7'd31,  12'h000, 1'b0);
    offer_request(pmrb_pkg::REQ_READ,       7'd32,  12'h000, 1'b0);
    offer_request(pmrb_pkg::REQ_READ,       7'd64,  12'h000, 1'b0);
    offer_request(REQ_UNUSED,               7'd127, 12'h000, 1'b0);
    release_bus();
    drain_results();

    // Random phases: sender rarely idle, then receiver rarely stalled, then no idling
    send_idle_pct  = 8;
    recv_stall_pct = 86;
    run_phase(PHASE_ITEMS, 1'b0);
    send_idle_pct  = 86;
    recv_stall_pct = 8;
    run_phase(PHASE_ITEMS, 1'b0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(PHASE_ITEMS, 1'b1);

    repeat (8) @(posedge clk);
    total = kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3];
    $display("%0d requests: %0d set-mux, %0d set-pull-up, %0d read, %0d unused code",
             total, kind_count[pmrb_pkg::REQ_SET_MUX], kind_count[pmrb_pkg::REQ_SET_PULLUP],
             kind_count[pmrb_pkg::REQ_READ], kind_count[REQ_UNUSED]);
    $display("%0d pin states checked over three idling mixes and one %0d-cycle hold-off",
             sb.checked, HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.outstanding());
      $display("FAIL");
    end
    $finish;
  end

endmodule
